// ===== hdl/edp_pkg.sv =====
// Shared types and constants for the encoder distance deceleration profile.
`timescale 1ns / 1ps
package edp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DIST_WIDTH_DEF  = 31;

  localparam int TARGET_W = 31;
  localparam int SPEED_W  = 9;
  localparam int RATIO_W  = 8;
  localparam int LIMIT_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam int QUOT_W    = 17;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIM = 3'd5;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd154;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  typedef logic [2:0] res_kind_t;
  localparam res_kind_t RES_START  = 3'd0;
  localparam res_kind_t RES_STALL  = 3'd1;
  localparam res_kind_t RES_ARRIVE = 3'd2;
  localparam res_kind_t RES_CRUISE = 3'd3;
  localparam res_kind_t RES_DECEL  = 3'd4;

  typedef struct packed {
    logic      capture;
    logic      eval;
    logic      sum;
    logic      accum;
    logic      prep;
    logic      div_init;
    logic      div_step;
    logic      square;
    logic      mult;
    logic      fin;
    logic      load_out;
    res_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic start;
    logic stall_stop;
    logic arrived;
    logic in_zone;
  } dp_status_t;

endpackage

// ===== hdl/encoder_distance_decel_profile_core.sv =====
// Sequence: a start or stall-stop beat goes capture, evaluate, result; other beats go on through
// sum, accumulate, prepare and check, and a deceleration beat also through the one-bit-per-cycle
// quotient divider, square, multiply and finish. One beat at a time: a new beat is taken once the
// sequencer is back in idle, while the previous result may still wait in the output register.
// Reset (rst_n, synchronous): config to defaults, baseline, distance and stall
// count cleared, no result pending.
`timescale 1ns / 1ps
module encoder_distance_decel_profile_core
  import edp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [COUNT_WIDTH-1:0] in_left_count,
  input  logic signed [COUNT_WIDTH-1:0] in_right_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SPEED_W-1:0]     out_speed,
  output logic                          out_arrived,
  output logic                          out_stalled,
  output logic                          out_decelerating,
  output logic [TARGET_W-1:0]           out_distance_travelled
);

  dp_cmd_t    cmd;
  dp_status_t status;

  edp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  edp_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DIST_WIDTH  (DIST_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_command             (in_command),
    .in_left_count          (in_left_count),
    .in_right_count         (in_right_count),
    .cmd                    (cmd),
    .status                 (status),
    .out_speed              (out_speed),
    .out_arrived            (out_arrived),
    .out_stalled            (out_stalled),
    .out_decelerating       (out_decelerating),
    .out_distance_travelled (out_distance_travelled)
  );

endmodule

// ===== hdl/edp_ctrl.sv =====
// Sequencer for the deceleration profile: steps the datapath through one beat.
`timescale 1ns / 1ps
module edp_ctrl
  import edp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EVAL   = 4'd1;
  localparam logic [3:0] ST_SUM    = 4'd2;
  localparam logic [3:0] ST_ACCUM  = 4'd3;
  localparam logic [3:0] ST_PREP   = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_SQR    = 4'd7;
  localparam logic [3:0] ST_MULT   = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;
  localparam logic [3:0] ST_RESULT = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  res_kind_t            kind_r, kind_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.kind      = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.start) begin
          kind_nxt  = RES_START;
          state_nxt = ST_RESULT;
        end else if (status.stall_stop) begin
          kind_nxt  = RES_STALL;
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.arrived) begin
          kind_nxt  = RES_ARRIVE;
          state_nxt = ST_RESULT;
        end else if (!status.in_zone) begin
          kind_nxt  = RES_CRUISE;
          state_nxt = ST_RESULT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        kind_nxt  = RES_DECEL;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      kind_r      <= RES_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/edp_datapath.sv =====
// Datapath: config registers, distance accumulator, divider, multiplies, result register.
`timescale 1ns / 1ps
module edp_datapath
  import edp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_command,
  input  logic signed [COUNT_WIDTH-1:0] in_left_count,
  input  logic signed [COUNT_WIDTH-1:0] in_right_count,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  output logic signed [SPEED_W-1:0]     out_speed,
  output logic                          out_arrived,
  output logic                          out_stalled,
  output logic                          out_decelerating,
  output logic [TARGET_W-1:0]           out_distance_travelled
);

  localparam int CW   = COUNT_WIDTH;
  localparam int DW   = DIST_WIDTH;
  localparam int CMPW = (DW > TARGET_W) ? DW : TARGET_W;
  localparam int AW   = ((CW + 1 > DW) ? CW + 1 : DW) + 1;
  localparam int ZPW  = TARGET_W + RATIO_W;
  localparam int SQW  = 2 * QUOT_W;
  localparam int PRW  = SPEED_W + 1 + SQW;
  localparam int ACW  = PRW + 1;
  localparam int FRAC = 32;

  // configuration
  logic [TARGET_W-1:0]       target_r;
  logic signed [SPEED_W-1:0] cruise_r;
  logic signed [SPEED_W-1:0] min_r;
  logic [RATIO_W-1:0]        ratio_r;
  logic                      stall_en_r;
  logic [LIMIT_W-1:0]        limit_r;

  // state
  logic [CW-1:0]      prev_l_r, prev_r_r;
  logic [DW-1:0]      trav_r;
  logic [LIMIT_W-1:0] stall_cnt_r, stall_cnt_nxt;

  // working registers
  logic                 cmd_r;
  logic [CW-1:0]        cap_l_r, cap_r_r;
  logic [CW-1:0]        dl_r, dr_r;
  logic [CW:0]          abs_r;
  logic                 arrived_r;
  logic [TARGET_W-1:0]  rem_r, zone_r;
  logic [TARGET_W:0]    div_rem_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [SQW-1:0]       sq_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;

  // result register
  logic signed [SPEED_W-1:0] out_speed_r;
  logic                      out_arrived_r, out_stalled_r, out_decel_r;
  logic [TARGET_W-1:0]       out_dist_r;

  logic                 unchanged;
  logic                 trav_ge;
  logic [CMPW-1:0]      trav_ext, target_ext;
  logic signed [CW:0]   dsum;
  logic [CW:0]          dabs;
  logic [AW-1:0]        tsum;
  logic [ZPW-1:0]       zone_prod;
  logic [TARGET_W:0]    div_sh;
  logic                 div_ge;
  logic [SQW-1:0]       sq_full;
  logic signed [SPEED_W:0]   speed_diff;
  logic signed [ACW-1:0]     min_scaled;
  logic signed [ACW-FRAC-1:0] acc_hi;
  logic signed [ACW-FRAC-1:0] speed_trunc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      cruise_r   <= '0;
      min_r      <= '0;
      ratio_r    <= RATIO_RESET;
      stall_en_r <= 1'b0;
      limit_r    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:    target_r   <= cfg_wdata[TARGET_W-1:0];
        REG_CRUISE:    cruise_r   <= cfg_wdata[SPEED_W-1:0];
        REG_MIN:       min_r      <= cfg_wdata[SPEED_W-1:0];
        REG_RATIO:     ratio_r    <= cfg_wdata[RATIO_W-1:0];
        REG_STALL_EN:  stall_en_r <= cfg_wdata[0];
        REG_STALL_LIM: limit_r    <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign unchanged  = (cap_l_r == prev_l_r) && (cap_r_r == prev_r_r);
  assign trav_ext   = CMPW'(trav_r);
  assign target_ext = CMPW'(target_r);
  assign trav_ge    = trav_ext >= target_ext;

  always_comb begin
    if (stall_en_r && unchanged) begin
      stall_cnt_nxt = (stall_cnt_r == '1) ? stall_cnt_r : stall_cnt_r + 1'b1;
    end else begin
      stall_cnt_nxt = '0;
    end
  end

  assign status.start      = cmd_r;
  assign status.stall_stop = stall_en_r && unchanged && (stall_cnt_nxt > limit_r);
  assign status.arrived    = arrived_r;
  assign status.in_zone    = (zone_r != '0) && (rem_r <= zone_r);

  assign dsum      = $signed({dl_r[CW-1], dl_r}) + $signed({dr_r[CW-1], dr_r});
  assign dabs      = dsum[CW] ? (CW+1)'(-dsum) : dsum;
  assign tsum      = AW'(trav_r) + AW'(abs_r);
  assign zone_prod = ZPW'(target_r) * ZPW'(ratio_r);
  assign div_sh    = {div_rem_r[TARGET_W-1:0], 1'b0};
  assign div_ge    = div_sh >= {1'b0, zone_r};
  assign sq_full   = SQW'(quot_r) * SQW'(quot_r);
  assign speed_diff = (SPEED_W+1)'(cruise_r) - (SPEED_W+1)'(min_r);
  assign min_scaled = ACW'(min_r) <<< FRAC;
  assign acc_hi     = acc_r[ACW-1:FRAC];
  assign speed_trunc = (acc_r[ACW-1] && (acc_r[FRAC-1:0] != '0)) ? acc_hi + 1'b1 : acc_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      trav_r      <= '0;
      stall_cnt_r <= '0;
    end else begin
      if (cmd.eval) begin
        if (cmd_r) begin
          prev_l_r    <= cap_l_r;
          prev_r_r    <= cap_r_r;
          trav_r      <= '0;
          stall_cnt_r <= '0;
        end else begin
          stall_cnt_r <= stall_cnt_nxt;
        end
      end
      if (cmd.accum) begin
        trav_r   <= (tsum > AW'({DW{1'b1}})) ? {DW{1'b1}} : tsum[DW-1:0];
        prev_l_r <= cap_l_r;
        prev_r_r <= cap_r_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      cap_l_r <= in_left_count;
      cap_r_r <= in_right_count;
    end
    if (cmd.eval) begin
      dl_r <= cap_l_r - prev_l_r;
      dr_r <= cap_r_r - prev_r_r;
    end
    if (cmd.sum) begin
      abs_r <= dabs;
    end
    if (cmd.prep) begin
      arrived_r <= trav_ge;
      rem_r     <= TARGET_W'(target_ext - trav_ext);
      zone_r    <= zone_prod[ZPW-1:RATIO_W];
    end
    if (cmd.div_init) begin
      // remaining never exceeds the zone, so the top quotient bit is an equality test
      div_rem_r <= (rem_r == zone_r) ? '0 : {1'b0, rem_r};
      quot_r    <= QUOT_W'(rem_r == zone_r);
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_sh - {1'b0, zone_r} : div_sh;
      quot_r    <= {quot_r[QUOT_W-2:0], div_ge};
    end
    if (cmd.square) begin
      sq_r <= sq_full;
    end
    if (cmd.mult) begin
      prod_r <= speed_diff * $signed({1'b0, sq_r[SQW-2:0]});
    end
    if (cmd.fin) begin
      acc_r <= min_scaled + ACW'(prod_r);
    end
    if (cmd.load_out) begin
      out_speed_r   <= '0;
      out_arrived_r <= 1'b0;
      out_stalled_r <= 1'b0;
      out_decel_r   <= 1'b0;
      out_dist_r    <= trav_ext[TARGET_W-1:0];
      case (cmd.kind)
        RES_START: begin
          out_dist_r <= '0;
        end
        RES_STALL: begin
          out_arrived_r <= trav_ge;
          out_stalled_r <= 1'b1;
        end
        RES_ARRIVE: begin
          out_arrived_r <= 1'b1;
        end
        RES_CRUISE: begin
          out_speed_r <= cruise_r;
        end
        RES_DECEL: begin
          out_speed_r <= speed_trunc[SPEED_W-1:0];
          out_decel_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_speed              = out_speed_r;
  assign out_arrived            = out_arrived_r;
  assign out_stalled            = out_stalled_r;
  assign out_decelerating       = out_decel_r;
  assign out_distance_travelled = out_dist_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the encoder distance deceleration profile core.
`timescale 1ns / 1ps
module tb_top;
  import edp_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;
  localparam logic [TARGET_W-1:0] DIST_MAX = '1;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 1350;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      arrived;
    logic                      stalled;
    logic                      decel;
    logic [TARGET_W-1:0]       travelled;
  } profile_t;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  cmd;
    logic [CW-1:0]         lc;
    logic [CW-1:0]         rc;
    logic                  typed;
    profile_t              typed_res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic signed [CW-1:0] in_left_count = '0;
  logic signed [CW-1:0] in_right_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SPEED_W-1:0] out_speed;
  logic out_arrived;
  logic out_stalled;
  logic out_decelerating;
  logic [TARGET_W-1:0] out_distance_travelled;

  // predictor copy of registers and state
  logic [TARGET_W-1:0] m_target = '0;
  logic signed [SPEED_W-1:0] m_cruise = '0;
  logic signed [SPEED_W-1:0] m_min = '0;
  logic [RATIO_W-1:0] m_ratio = RATIO_RESET;
  logic m_stall_en = 1'b0;
  logic [LIMIT_W-1:0] m_stall_lim = LIMIT_RESET;
  logic [CW-1:0] base_left = '0;
  logic [CW-1:0] base_right = '0;
  logic [TARGET_W-1:0] dist_acc = '0;
  logic [3:0] still_run = '0;

  profile_t pending_profiles[$];
  row_t directed[$];

  int errors = 0;
  int n_beats = 0;
  int n_results = 0;
  int n_decel = 0;
  int n_stalled = 0;
  int n_arrived = 0;
  int n_phases = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_cycle = 0;

  always #10 clk = ~clk;

  encoder_distance_decel_profile_core uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_left_count          (in_left_count),
    .in_right_count         (in_right_count),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_speed              (out_speed),
    .out_arrived            (out_arrived),
    .out_stalled            (out_stalled),
    .out_decelerating       (out_decelerating),
    .out_distance_travelled (out_distance_travelled)
  );

  function automatic profile_t profile_step(input logic cmd, input logic [CW-1:0] lc,
                                            input logic [CW-1:0] rc);
    profile_t res;
    logic [CW-1:0] dl;
    logic [CW-1:0] dr;
    logic signed [CW+1:0] dsum;
    logic [CW+1:0] mag;
    logic [TARGET_W-1:0] add_d;
    logic [TARGET_W:0] sum_d;
    logic [TARGET_W-1:0] remaining;
    logic [TARGET_W+RATIO_W-1:0] zone_full;
    logic [TARGET_W-1:0] zone;
    logic [TARGET_W+15:0] quot;
    logic [16:0] ratio_q;
    logic [33:0] ratio_sq;
    longint acc;
    longint spd;
    res = '0;
    if (cmd == CMD_START) begin
      base_left = lc;
      base_right = rc;
      dist_acc = '0;
      still_run = '0;
      return res;
    end
    if (m_stall_en) begin
      if (lc == base_left && rc == base_right) begin
        if (still_run != 4'hF) still_run++;
        if (still_run > m_stall_lim) begin
          res.stalled = 1'b1;
          res.arrived = (dist_acc >= m_target);
          res.travelled = dist_acc;
          return res;
        end
      end else begin
        still_run = '0;
      end
    end else begin
      still_run = '0;
    end
    dl = lc - base_left;
    dr = rc - base_right;
    dsum = $signed({{2{dl[CW-1]}}, dl}) + $signed({{2{dr[CW-1]}}, dr});
    mag = dsum[CW+1] ? -dsum : dsum;
    add_d = (mag > DIST_MAX) ? DIST_MAX : mag[TARGET_W-1:0];
    sum_d = dist_acc + add_d;
    dist_acc = (sum_d > DIST_MAX) ? DIST_MAX : sum_d[TARGET_W-1:0];
    base_left = lc;
    base_right = rc;
    res.travelled = dist_acc;
    if (dist_acc >= m_target) begin
      res.arrived = 1'b1;
    end else begin
      remaining = m_target - dist_acc;
      zone_full = m_target * m_ratio;
      zone = zone_full[TARGET_W+RATIO_W-1:RATIO_W];
      res.speed = m_cruise;
      if (zone != 0 && remaining <= zone) begin
        quot = {remaining, 16'h0000} / zone;
        ratio_q = quot[16:0];
        ratio_sq = ratio_q * ratio_q;
        acc = longint'(m_min) * (longint'(1) <<< 32)
              + (longint'(m_cruise) - longint'(m_min)) * longint'(ratio_sq);
        spd = acc / (longint'(1) <<< 32);
        res.speed = SPEED_W'(spd);
        res.decel = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic profile_t outcome(input int spd, input int arr, input int stl,
                                       input int dec, input longint d);
    profile_t res;
    res.speed = SPEED_W'(spd);
    res.arrived = arr[0];
    res.stalled = stl[0];
    res.decel = dec[0];
    res.travelled = TARGET_W'(d);
    return res;
  endfunction

  function automatic void tab_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    row.cmd = CMD_SAMPLE;
    row.lc = '0;
    row.rc = '0;
    row.typed = 1'b0;
    row.typed_res = '0;
    directed.push_back(row);
  endfunction

  function automatic void tab_beat(input logic cmd, input logic [CW-1:0] lc,
                                   input logic [CW-1:0] rc, input logic typed,
                                   input profile_t typed_res);
    row_t row;
    row.kind = ROW_BEAT;
    row.idx = '0;
    row.data = '0;
    row.cmd = cmd;
    row.lc = lc;
    row.rc = rc;
    row.typed = typed;
    row.typed_res = typed_res;
    directed.push_back(row);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] speed_word();
    logic [CFG_DATA_W-1:0] w;
    int v;
    w = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0: v = -255;
      1: v = 255;
      2: v = 0;
      default: v = $urandom_range(0, 510) - 255;
    endcase
    w[SPEED_W-1:0] = v[SPEED_W-1:0];
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TARGET:    m_target = data[TARGET_W-1:0];
      REG_CRUISE:    m_cruise = data[SPEED_W-1:0];
      REG_MIN:       m_min = data[SPEED_W-1:0];
      REG_RATIO:     m_ratio = data[RATIO_W-1:0];
      REG_STALL_EN:  m_stall_en = data[0];
      REG_STALL_LIM: m_stall_lim = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_beat(input logic cmd, input logic [CW-1:0] lc, input logic [CW-1:0] rc,
                           input logic typed, input profile_t typed_res);
    profile_t pred;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_left_count <= lc;
    in_right_count <= rc;
    do @(posedge clk); while (in_stall);
    pred = profile_step(cmd, lc, rc);
    pending_profiles.push_back(typed ? typed_res : pred);
    n_beats++;
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CW-1:0] cur_l;
    logic [CW-1:0] cur_r;
    logic [CFG_DATA_W-1:0] data;
    logic cmd;
    int step;
    int hold;
    int kind;
    int steps;
    int n_rand;

    // reset defaults: zero target, counter extremes and rollover
    tab_beat(CMD_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, outcome(0, 1, 0, 0, 0));
    tab_beat(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, outcome(0, 1, 0, 0, 1));
    tab_beat(CMD_START, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, outcome(0, 0, 0, 0, 0));
    tab_beat(CMD_SAMPLE, 32'h8000_0001, 32'h0000_0002, 1'b1, outcome(0, 1, 0, 0, 5));
    // short move: cruise, zone, stall stop, reverse, arrival
    tab_cfg(REG_TARGET, 31'd1000);
    tab_cfg(REG_CRUISE, 31'd200);
    tab_cfg(REG_MIN, 31'd40);
    tab_cfg(REG_RATIO, 31'd128);
    tab_cfg(REG_STALL_EN, 31'd1);
    tab_cfg(REG_STALL_LIM, 31'd2);
    tab_beat(CMD_START, 32'd0, 32'd0, 1'b1, outcome(0, 0, 0, 0, 0));
    tab_beat(CMD_SAMPLE, 32'd100, 32'd100, 1'b1, outcome(200, 0, 0, 0, 200));
    tab_beat(CMD_SAMPLE, 32'd300, 32'd300, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd300, 32'd300, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd300, 32'd300, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd300, 32'd300, 1'b1, outcome(0, 0, 1, 0, 600));
    tab_beat(CMD_SAMPLE, 32'd400, 32'd350, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd300, 32'd300, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd310, 32'd290, 1'b0, '0);
    tab_beat(CMD_SAMPLE, 32'd400, 32'd400, 1'b1, outcome(0, 1, 0, 0, 1100));
    // register extremes, distance saturation, zero zone, stall detector off/on
    tab_cfg(REG_TARGET, 31'h7FFF_FFFF);
    tab_cfg(REG_CRUISE, 31'h101);
    tab_cfg(REG_MIN, 31'd255);
    tab_cfg(REG_RATIO, 31'd255);
    tab_cfg(REG_STALL_LIM, 31'd15);
    tab_beat(CMD_START, 32'hFFFF_FFFB, 32'd7, 1'b1, outcome(0, 0, 0, 0, 0));
    tab_beat(CMD_SAMPLE, 32'd995, 32'd7, 1'b1, outcome(-255, 0, 0, 0, 1000));
    tab_beat(CMD_SAMPLE, 32'h8000_03E2, 32'h8000_0006, 1'b1,
             outcome(0, 1, 0, 0, 31'h7FFF_FFFF));
    tab_beat(CMD_SAMPLE, 32'h0000_03E2, 32'h8000_0007, 1'b0, '0);
    tab_beat(CMD_START, 32'd0, 32'd0, 1'b1, outcome(0, 0, 0, 0, 0));
    tab_beat(CMD_SAMPLE, 32'h1000_0000, 32'h1000_0000, 1'b0, '0);
    tab_cfg(REG_RATIO, 31'd0);
    tab_beat(CMD_SAMPLE, 32'h1000_0001, 32'h1000_0000, 1'b1,
             outcome(-255, 0, 0, 0, 31'h2000_0001));
    tab_cfg(REG_STALL_EN, 31'd0);
    tab_beat(CMD_SAMPLE, 32'h1000_0001, 32'h1000_0000, 1'b1,
             outcome(-255, 0, 0, 0, 31'h2000_0001));
    tab_cfg(REG_STALL_EN, 31'd1);
    tab_cfg(REG_STALL_LIM, 31'd0);
    tab_beat(CMD_SAMPLE, 32'h1000_0001, 32'h1000_0000, 1'b1,
             outcome(0, 0, 1, 0, 31'h2000_0001));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_beat(directed[i].cmd, directed[i].lc, directed[i].rc, directed[i].typed,
                  directed[i].typed_res);
        pace_sender();
      end
    end

    n_rand = 0;
    while (n_rand < RANDOM_BEATS) begin
      drain_results();
      n_phases++;
      case ($urandom_range(0, 9))
        0: data = '0;
        1: data = DIST_MAX;
        2: data = CFG_DATA_W'($urandom_range(1, 60));
        default: data = CFG_DATA_W'($urandom_range(100, 20000));
      endcase
      write_reg(REG_TARGET, data);
      write_reg(REG_CRUISE, speed_word());
      write_reg(REG_MIN, speed_word());
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 4))
        0: data[RATIO_W-1:0] = '0;
        1: data[RATIO_W-1:0] = '1;
        default: data[RATIO_W-1:0] = RATIO_W'($urandom_range(1, 254));
      endcase
      write_reg(REG_RATIO, data);
      data = CFG_DATA_W'($urandom);
      write_reg(REG_STALL_EN, data);
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 3))
        0: data[LIMIT_W-1:0] = '0;
        1: data[LIMIT_W-1:0] = '1;
        default: data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 14));
      endcase
      write_reg(REG_STALL_LIM, data);

      cur_l = $urandom;
      cur_r = $urandom;
      if ($urandom_range(0, 3) == 0) cur_l = $urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'h7FFF_FF00;
      if ($urandom_range(0, 3) == 0) cur_r = $urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'h7FFF_FF00;
      send_beat(CMD_START, cur_l, cur_r, 1'b0, '0);
      n_rand++;
      pace_sender();

      step = int'(m_target / $urandom_range(8, 40)) + 1;
      steps = $urandom_range(15, 70);
      hold = 0;
      repeat (steps) begin
        cmd = CMD_SAMPLE;
        if (hold > 0) begin
          hold--;
        end else begin
          kind = $urandom_range(0, 39);
          if (kind == 0) begin
            cur_l = $urandom;
            cur_r = $urandom;
          end else if (kind == 1) begin
            cmd = CMD_START;
          end else if (kind < 5) begin
            hold = $urandom_range(1, 17);
          end else begin
            cur_l = cur_l + CW'($urandom_range(0, step + step / 4) - step / 4);
            cur_r = cur_r + CW'($urandom_range(0, step + step / 4) - step / 4);
          end
        end
        send_beat(cmd, cur_l, cur_r, 1'b0, '0);
        n_rand++;
        pace_sender();
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    $display("Covered %0d beats and %0d results: %0d decelerating, %0d stall stops, %0d arrived.",
             n_beats, n_results, n_decel, n_stalled, n_arrived);
    $display("Directed table plus %0d random register settings with mixed idle and stall.",
             n_phases);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    profile_t got;
    profile_t exp_res;
    got = {out_speed, out_arrived, out_stalled, out_decelerating, out_distance_travelled};
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (got.decel) n_decel++;
      if (got.stalled) n_stalled++;
      if (got.arrived) n_arrived++;
      if (pending_profiles.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: speed=%0d arrived=%0b stalled=%0b decel=%0b dist=%0d",
                 $time, got.speed, got.arrived, got.stalled, got.decel, got.travelled);
      end else begin
        exp_res = pending_profiles.pop_front();
        if (got.speed !== exp_res.speed || got.arrived !== exp_res.arrived ||
            got.stalled !== exp_res.stalled || got.decel !== exp_res.decel ||
            got.travelled !== exp_res.travelled) begin
          errors++;
          $display("%0t mismatch expected: speed=%0d arrived=%0b stalled=%0b decel=%0b dist=%0d",
                   $time, exp_res.speed, exp_res.arrived, exp_res.stalled, exp_res.decel,
                   exp_res.travelled);
          $display("%0t mismatch actual:   speed=%0d arrived=%0b stalled=%0b decel=%0b dist=%0d",
                   $time, got.speed, got.arrived, got.stalled, got.decel, got.travelled);
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((rx_cycle % 5) < 3);
    endcase
    rx_cycle++;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
